// ===== rtl/olief_pkg.sv =====
`timescale 1ns / 1ps

package olief_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Field widths of the stream payloads.
  localparam int OPCODE_W   = 2;
  localparam int POSITION_W = 7;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int FIDX_W     = 6;
  localparam int COUNT_W    = 7;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_FIND   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_FIND = 1'b1
  } state_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic ins;
    logic del;
    logic cmp;
  } cell_ctl_t;

endpackage

// ===== rtl/olief_cell.sv =====
`timescale 1ns / 1ps

module olief_cell #(
  parameter int INDEX      = 0,
  parameter int CNT_W      = 7,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  olief_pkg::cell_ctl_t  ctl,
  input  logic [CNT_W-1:0]      pos,
  input  logic [CNT_W-1:0]      cnt,
  input  logic [DATA_WIDTH-1:0] word_in,
  input  logic [DATA_WIDTH-1:0] prev_word,
  input  logic [DATA_WIDTH-1:0] next_word,
  output logic [DATA_WIDTH-1:0] word,
  output logic                  match
);
  import olief_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic [DATA_WIDTH-1:0] word_next;
  logic                  live;

  assign live = MY_IDX < cnt;

  always_comb begin
    word_next = word;
    if (ctl.ins) begin
      if (MY_IDX > pos) begin
        word_next = prev_word;
      end else if (MY_IDX == pos) begin
        word_next = word_in;
      end
    end else if (ctl.del) begin
      if (MY_IDX >= pos) begin
        word_next = next_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
    if (ctl.cmp) begin
      match <= live && (word == word_in);
    end
  end

endmodule

// ===== rtl/olief_first.sv =====
`timescale 1ns / 1ps

module olief_first #(
  parameter int N  = 64,
  parameter int IW = 6
) (
  input  logic [N-1:0]  bits,
  output logic          hit,
  output logic [IW-1:0] index
);

  // Scanning from the top down leaves the lowest set bit in index.
  always_comb begin
    index = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (bits[i]) begin
        index = IW'(i);
      end
    end
  end

  assign hit = |bits;

endmodule

// ===== rtl/ordered_list_insert_erase_find_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload (tdata, lowest bit first)
// s_axis    in         opcode[1:0] position[8:2] value[40:9], zero fill to 48
// m_axis    out        status[1:0] found[2] found_index[8:3] count[15:9]
//
// Insert and erase update every cell of the row in the same cycle: each cell
// loads its neighbor or the new word, or keeps its word. For find, the cells
// compare in parallel into registered match bits, then a priority encoder
// picks the lowest hit. One command is in flight at a time; a new one is taken
// once the output register is free or being drained. Reset clears the state,
// count and valid flag, not the words: only words below the count are read.
module ordered_list_insert_erase_find_unit #(
  parameter int CAPACITY   = olief_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = olief_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // opcode, position, value
  input  logic [olief_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status, found, found_index, count
  output logic [olief_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import olief_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = (CW > POSITION_W) ? CW : POSITION_W;

  state_t                state, state_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic                  out_valid;
  logic                  load_out;
  logic [OUT_TDATA_W-1:0] out_data, out_data_next;

  logic                  in_xfer;
  opcode_t               op;
  logic [POSITION_W-1:0] pos_in;
  logic [VALUE_W-1:0]    value_in;
  logic [DATA_WIDTH-1:0] word_in;
  logic [PW-1:0]         pos_w, cnt_w;
  logic                  ins_ok, del_ok, is_full;
  cell_ctl_t             ctl;

  logic [DATA_WIDTH-1:0] cell_word [CAPACITY];
  logic [CAPACITY-1:0]   match;
  logic                  hit;
  logic [IW-1:0]         hit_idx;

  assign op       = opcode_t'(s_axis_tdata[1:0]);
  assign pos_in   = s_axis_tdata[8:2];
  assign value_in = s_axis_tdata[40:9];
  assign word_in  = DATA_WIDTH'(64'(value_in));

  assign s_axis_tready = (state == S_IDLE) && (!out_valid || m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign pos_w   = PW'(pos_in);
  assign cnt_w   = PW'(cnt);
  assign is_full = (cnt == CW'(CAPACITY));
  assign ins_ok  = (pos_w <= cnt_w) && !is_full;
  assign del_ok  = pos_w < cnt_w;

  assign ctl.ins = in_xfer && (op == OP_INSERT) && ins_ok;
  assign ctl.del = in_xfer && (op == OP_ERASE) && del_ok;
  assign ctl.cmp = in_xfer && (op == OP_FIND);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    olief_cell #(
      .INDEX      (i),
      .CNT_W      (CW),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (CW'(pos_in)),
      .cnt       (cnt),
      .word_in   (word_in),
      .prev_word (cell_word[(i > 0) ? i - 1 : i]),
      .next_word (cell_word[(i < CAPACITY - 1) ? i + 1 : i]),
      .word      (cell_word[i]),
      .match     (match[i])
    );
  end

  olief_first #(
    .N  (CAPACITY),
    .IW (IW)
  ) u_first (
    .bits  (match),
    .hit   (hit),
    .index (hit_idx)
  );

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    load_out      = 1'b0;
    out_data_next = out_data;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (op)
            OP_INSERT: begin
              load_out = 1'b1;
              if (!(pos_w <= cnt_w)) begin
                out_data_next = {COUNT_W'(cnt), FIDX_W'(0), 1'b0, ST_RANGE};
              end else if (is_full) begin
                out_data_next = {COUNT_W'(cnt), FIDX_W'(0), 1'b0, ST_FULL};
              end else begin
                cnt_next      = cnt + 1'b1;
                out_data_next = {COUNT_W'(cnt_next), FIDX_W'(0), 1'b0, ST_OK};
              end
            end
            OP_ERASE: begin
              load_out = 1'b1;
              if (del_ok) begin
                cnt_next      = cnt - 1'b1;
                out_data_next = {COUNT_W'(cnt_next), FIDX_W'(0), 1'b0, ST_OK};
              end else begin
                out_data_next = {COUNT_W'(cnt), FIDX_W'(0), 1'b0, ST_RANGE};
              end
            end
            OP_FIND: begin
              state_next = S_FIND;
            end
            OP_NOP: begin
              load_out      = 1'b1;
              out_data_next = {COUNT_W'(cnt), FIDX_W'(0), 1'b0, ST_OK};
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_FIND: begin
        // The output register was freed when the find was taken.
        load_out      = 1'b1;
        state_next    = S_IDLE;
        out_data_next = {COUNT_W'(cnt), hit ? FIDX_W'(hit_idx) : FIDX_W'(0), hit, ST_OK};
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_data_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

`ifndef SYNTHESIS
  a_find_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND) |-> !out_valid)
    else $error("find result would overwrite a pending transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_find_enters: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (op == OP_FIND)) |=> (state == S_FIND))
    else $error("find transfer did not start the encode cycle");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> (cnt == $past(cnt) + 1'b1))
    else $error("insert did not advance the count");
`endif

endmodule
